@@ rtl/scma_pkg.sv @@
// Shared types and constants for the six-channel moving average.
package scma_pkg;

  localparam int SMP_W      = 16;  // sample and mean width
  localparam int NCHAN      = 6;   // sensor channels per item
  localparam int Q_W        = 17;  // unsigned quotient magnitude, up to 32768
  localparam int WINDOW_DEF = 8;   // default window length

  typedef logic signed [SMP_W-1:0] sample_t;

  // Pipeline strobes shared by all lanes
  typedef struct packed {
    logic ld;      // item accepted: write history, read oldest entry
    logic mv1;     // stage 1 -> running sum
    logic mv2;     // running sum -> reciprocal multiply
    logic mv3;     // multiply -> remainder/correction stage
    logic old_ok;  // oldest entry has been written since reset
  } lane_ctl_t;

endpackage

@@ rtl/scma_ram.sv @@
// Generic single-clock RAM, one write and one registered read port.
module scma_ram #(
  parameter int WIDTH = scma_pkg::SMP_W,
  parameter int DEPTH = scma_pkg::WINDOW_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/scma_div.sv @@
// Pipelined signed divide by the window length, truncating toward zero.
module scma_div #(
  parameter int WINDOW  = scma_pkg::WINDOW_DEF,
  localparam int SLOT_W = $clog2(WINDOW),
  localparam int SUM_W  = scma_pkg::SMP_W + SLOT_W
) (
  input  logic                    clk,
  input  logic                    en_in,
  input  logic                    en_mid,
  input  logic signed [SUM_W-1:0] sum,
  output scma_pkg::sample_t       quot
);
  import scma_pkg::*;

  localparam int MAG_W = SUM_W;
  localparam int REM_W = SLOT_W + 2;
  // floor(2^MAG_W / WINDOW); estimate is low by at most one
  localparam logic [MAG_W-1:0] RECIP = MAG_W'((64'd1 << MAG_W) / WINDOW);

  logic [MAG_W-1:0]   mag_in;
  logic               neg3;
  logic [MAG_W-1:0]   mag3;
  logic [2*MAG_W-1:0] prod3;
  logic [Q_W-1:0]     q0;
  logic [MAG_W-1:0]   qw;
  logic [MAG_W-1:0]   rem_full;
  logic               neg4;
  logic [Q_W-1:0]     q4;
  logic [REM_W-1:0]   rem4;
  logic [Q_W-1:0]     q_fix;

  assign mag_in = sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);

  always_ff @(posedge clk) begin
    if (en_in) begin
      neg3  <= sum[SUM_W-1];
      mag3  <= mag_in;
      prod3 <= (2*MAG_W)'(mag_in) * (2*MAG_W)'(RECIP);
    end
  end

  assign q0       = prod3[MAG_W +: Q_W];
  assign qw       = MAG_W'(q0) * MAG_W'(WINDOW);
  assign rem_full = mag3 - qw;

  always_ff @(posedge clk) begin
    if (en_mid) begin
      neg4 <= neg3;
      q4   <= q0;
      rem4 <= rem_full[REM_W-1:0];
    end
  end

  // Remainder below 2*WINDOW: one correction step
  assign q_fix = q4 + Q_W'(rem4 >= REM_W'(WINDOW));
  assign quot  = neg4 ? SMP_W'(-q_fix) : SMP_W'(q_fix);

endmodule

@@ rtl/scma_lane.sv @@
// One channel: sample history, running window sum and mean divider.
module scma_lane #(
  parameter int WINDOW  = scma_pkg::WINDOW_DEF,
  localparam int SLOT_W = $clog2(WINDOW)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  scma_pkg::lane_ctl_t   ctl,
  input  logic [SLOT_W-1:0]     slot,
  input  scma_pkg::sample_t     smp_in,
  output scma_pkg::sample_t     avg
);
  import scma_pkg::*;

  localparam int SUM_W = SMP_W + SLOT_W;

  sample_t                  smp1;
  sample_t                  old_raw;
  logic signed [SUM_W-1:0]  old_ext;
  logic signed [SUM_W-1:0]  acc;
  logic signed [SUM_W-1:0]  acc_next;

  scma_ram #(
    .WIDTH(SMP_W),
    .DEPTH(WINDOW)
  ) u_hist (
    .clk  (clk),
    .we   (ctl.ld),
    .waddr(slot),
    .wdata(smp_in),
    .re   (ctl.ld),
    .raddr(slot),
    .rdata(old_raw)
  );

  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      smp1 <= smp_in;
    end
  end

  // Never-written entries count as zero
  assign old_ext  = ctl.old_ok ? SUM_W'(old_raw) : '0;
  assign acc_next = acc + SUM_W'(smp1) - old_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctl.mv1) begin
      acc <= acc_next;
    end
  end

  scma_div #(
    .WINDOW(WINDOW)
  ) u_div (
    .clk   (clk),
    .en_in (ctl.mv2),
    .en_mid(ctl.mv3),
    .sum   (acc),
    .quot  (avg)
  );

endmodule

@@ rtl/six_channel_moving_average.sv @@
// Six-channel boxcar moving average, top level.
//
// Usage:
//   Input channel: in_valid/in_ready carry one item of six signed 16-bit
//   samples (three accelerometer axes, three gyro rates). Output channel:
//   out_valid/out_ready carry the six window means, truncated toward zero.
//   Exactly one result item per input item, in order.
// Path: an accepted item passes the history read at the accept edge, then
//   the running sum, reciprocal multiply, remainder correction and output
//   register, where it raises out_valid and holds it until taken.
// Throughput: one item per cycle if out_ready keeps up. With running sums, an item
//   costs one history RAM write/read at the same slot plus one add/subtract.
// Reset: sums, slot pointer and per-slot written flags clear at once; the
//   history RAMs are not swept, unwritten slots read as zero. No wait
//   after reset.
// Stall: each stage advances only into a free or emptying stage, so bubbles
//   close up; with five items in flight and out_ready low, in_ready drops.
module six_channel_moving_average #(
  parameter int WINDOW = scma_pkg::WINDOW_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  scma_pkg::sample_t accel_x,
  input  scma_pkg::sample_t accel_y,
  input  scma_pkg::sample_t accel_z,
  input  scma_pkg::sample_t rate_roll,
  input  scma_pkg::sample_t rate_pitch,
  input  scma_pkg::sample_t rate_yaw,
  output logic              out_valid,
  input  logic              out_ready,
  output scma_pkg::sample_t avg_accel_x,
  output scma_pkg::sample_t avg_accel_y,
  output scma_pkg::sample_t avg_accel_z,
  output scma_pkg::sample_t avg_rate_roll,
  output scma_pkg::sample_t avg_rate_pitch,
  output scma_pkg::sample_t avg_rate_yaw
);
  import scma_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW);

  // Stage valids: 1 = history read, 2 = sum, 3 = multiply, 4 = correction
  logic              v1, v2, v3, v4;
  logic              rdy_out, rdy4, rdy3, rdy2;
  logic              ld, mv1, mv2, mv3, mv4;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_next;
  logic [WINDOW-1:0] hist_valid;   // slot written since reset
  logic              old_ok;
  lane_ctl_t         ctl;
  sample_t           smp_in [NCHAN];
  sample_t           lane_avg [NCHAN];
  sample_t           avg_q [NCHAN];

  // Ready chain: a stage can take an item when empty or moving on
  assign rdy_out  = !out_valid || out_ready;
  assign rdy4     = !v4 || rdy_out;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign in_ready = !v1 || rdy2;

  assign ld  = in_valid && in_ready;
  assign mv1 = v1 && rdy2;
  assign mv2 = v2 && rdy3;
  assign mv3 = v3 && rdy4;
  assign mv4 = v4 && rdy_out;

  assign slot_next = (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      v4         <= 1'b0;
      out_valid  <= 1'b0;
      slot       <= '0;
      hist_valid <= '0;
      old_ok     <= 1'b0;
    end else begin
      v1        <= ld  || (v1 && !mv1);
      v2        <= mv1 || (v2 && !mv2);
      v3        <= mv2 || (v3 && !mv3);
      v4        <= mv3 || (v4 && !mv4);
      out_valid <= mv4 || (out_valid && !out_ready);
      if (ld) begin
        slot             <= slot_next;
        hist_valid[slot] <= 1'b1;
        old_ok           <= hist_valid[slot];
      end
    end
  end

  assign ctl = '{ld: ld, mv1: mv1, mv2: mv2, mv3: mv3, old_ok: old_ok};

  assign smp_in[0] = accel_x;
  assign smp_in[1] = accel_y;
  assign smp_in[2] = accel_z;
  assign smp_in[3] = rate_roll;
  assign smp_in[4] = rate_pitch;
  assign smp_in[5] = rate_yaw;

  for (genvar c = 0; c < NCHAN; c++) begin : g_lane
    scma_lane #(
      .WINDOW(WINDOW)
    ) u_lane (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .slot  (slot),
      .smp_in(smp_in[c]),
      .avg   (lane_avg[c])
    );
  end

  // Merge: all six lane means land in one output register
  always_ff @(posedge clk) begin
    if (mv4) begin
      avg_q <= lane_avg;
    end
  end

  assign avg_accel_x    = avg_q[0];
  assign avg_accel_y    = avg_q[1];
  assign avg_accel_z    = avg_q[2];
  assign avg_rate_roll  = avg_q[3];
  assign avg_rate_pitch = avg_q[4];
  assign avg_rate_yaw   = avg_q[5];

  // Slot pointer steps once per accepted item and wraps at the window end
  a_slot_step: assert property (@(posedge clk) disable iff (rst)
    ld |=> slot == (($past(slot) == SLOT_W'(WINDOW - 1)) ? '0 : $past(slot) + 1'b1))
    else $error("slot pointer did not advance correctly");

  // A written slot is flagged so later reads use its contents
  a_slot_flag: assert property (@(posedge clk) disable iff (rst)
    ld |=> hist_valid[$past(slot)])
    else $error("written history slot not flagged");

  // A finished item moves into an empty output register at once
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (v4 && !out_valid) |=> out_valid)
    else $error("result not loaded into output register");

  // An empty pipeline never refuses an item
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    (!v1 && !v2 && !v3 && !v4 && !out_valid) |-> in_ready)
    else $error("empty pipeline not ready");

endmodule

@@ tb/sv/six_channel_moving_average_tb.sv @@
// Self-checking testbench for the six-channel moving average filter.
`timescale 1ns / 1ps

module six_channel_moving_average_tb;
  import scma_pkg::*;

  localparam int WIN         = WINDOW_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_AFTER  = 500;   // items accepted before the long receiver hold-off
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_WAIT  = 20;
  localparam int RAND_ITEMS  = 1880;

  // One item: channel 0 is accel_x ... channel 5 is rate_yaw
  typedef logic [NCHAN-1:0][SMP_W-1:0] frame_t;

  typedef struct {
    frame_t      samples;
    int unsigned gap;      // idle cycles the sender inserts after this item
  } stim_t;

  logic    clk       = 1'b0;
  logic    rst       = 1'b1;
  logic    in_valid  = 1'b0;
  logic    out_ready = 1'b0;
  frame_t  in_frame  = '0;
  logic    in_ready;
  logic    out_valid;
  sample_t avg_accel_x, avg_accel_y, avg_accel_z;
  sample_t avg_rate_roll, avg_rate_pitch, avg_rate_yaw;

  stim_t  pending_q[$];
  frame_t means_q[$];

  // Filter model state
  sample_t win_hist[NCHAN][WIN];
  int      win_slot;

  int          accepted_count = 0;
  int          total_items    = 0;
  int          err_count      = 0;
  int          cycle_count    = 0;
  int          hold_left      = 0;
  bit          hold_done      = 1'b0;
  int unsigned gap_left       = 0;
  int unsigned stall_left     = 0;
  stim_t       next_item;
  frame_t      got, want;

  string chan_name[NCHAN] = '{"avg_accel_x", "avg_accel_y", "avg_accel_z",
                              "avg_rate_roll", "avg_rate_pitch", "avg_rate_yaw"};

  always #1 clk = ~clk;

  six_channel_moving_average #(.WINDOW(WIN)) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .accel_x       (in_frame[0]),
    .accel_y       (in_frame[1]),
    .accel_z       (in_frame[2]),
    .rate_roll     (in_frame[3]),
    .rate_pitch    (in_frame[4]),
    .rate_yaw      (in_frame[5]),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .avg_accel_x   (avg_accel_x),
    .avg_accel_y   (avg_accel_y),
    .avg_accel_z   (avg_accel_z),
    .avg_rate_roll (avg_rate_roll),
    .avg_rate_pitch(avg_rate_pitch),
    .avg_rate_yaw  (avg_rate_yaw)
  );

  // Push one item into the windows and return the truncated means.
  function automatic frame_t update_window_means(frame_t s);
    frame_t res;
    int     acc;
    int     mean;
    for (int c = 0; c < NCHAN; c++) begin
      win_hist[c][win_slot] = sample_t'(s[c]);
      acc = 0;
      for (int k = 0; k < WIN; k++) acc += int'(win_hist[c][k]);
      mean   = acc / WIN;   // signed division truncates toward zero
      res[c] = mean[SMP_W-1:0];
    end
    win_slot = (win_slot == WIN - 1) ? 0 : win_slot + 1;
    return res;
  endfunction

  function automatic frame_t same_frame(sample_t v);
    frame_t f;
    for (int c = 0; c < NCHAN; c++) f[c] = v;
    return f;
  endfunction

  function automatic sample_t draw_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return sample_t'($urandom);
    if (r < 60) begin
      case ($urandom_range(0, 3))
        0:       return 16'sh7FFF;
        1:       return 16'sh8000;
        2:       return 16'sh0000;
        default: return 16'shFFFF;
      endcase
    end
    // small magnitudes exercise truncation of negative sums
    if (r < 85) return sample_t'(int'($urandom_range(0, 40)) - 20);
    if ($urandom_range(0, 1)) return sample_t'(32767 - int'($urandom_range(0, 15)));
    return sample_t'(-32768 + int'($urandom_range(0, 15)));
  endfunction

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Sender: offers pending items, keeps valid and payload steady until taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
      win_slot = 0;
      for (int c = 0; c < NCHAN; c++)
        for (int k = 0; k < WIN; k++) win_hist[c][k] = '0;
    end else begin
      if (in_valid && in_ready) begin
        means_q.push_back(update_window_means(in_frame));
        accepted_count <= accepted_count + 1;
      end
      if (in_valid && !in_ready) begin
        // stalled: hold item
      end else if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        next_item = pending_q.pop_front();
        in_frame <= next_item.samples;
        in_valid <= 1'b1;
        gap_left = next_item.gap;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off once traffic is flowing, so the pipe fills and in_ready drops.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_count >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: checks each accepted result, then picks next ready.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {avg_rate_yaw, avg_rate_pitch, avg_rate_roll,
               avg_accel_z, avg_accel_y, avg_accel_x};
        if (means_q.size() == 0) begin
          err_count++;
          if (err_count < 40)
            $display("%0t: unexpected result item, no expectation pending", $time);
        end else begin
          want = means_q.pop_front();
          for (int c = 0; c < NCHAN; c++) begin
            if (got[c] !== want[c]) begin
              err_count++;
              if (err_count < 40)
                $display("%0t: %s mismatch, expected %0d actual %0d", $time,
                         chan_name[c], $signed(want[c]), $signed(got[c]));
            end
          end
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (cycle_count % 3000 < 700) begin
        out_ready <= 1'b1;   // stretch with no receiver stalls
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:69]:  begin out_ready <= 1'b1; end
          [70:91]: begin out_ready <= 1'b0; stall_left = $urandom_range(0, 2); end
          [92:97]: begin out_ready <= 1'b0; stall_left = $urandom_range(3, 11); end
          default: begin out_ready <= 1'b0; stall_left = $urandom_range(24, 79); end
        endcase
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    stim_t       s;
    frame_t      f;
    int unsigned mode;
    int unsigned run_len;
    int          n;
    bit          quiet;

    // Directed: negative sum truncating to zero against the reset zeros
    s.gap = 0;
    s.samples = same_frame(-16'sd7);
    pending_q.push_back(s);
    s.samples = same_frame(16'sd7);
    pending_q.push_back(s);
    // full window of maximum, then full window of minimum
    for (int i = 0; i < WIN; i++) begin
      s.samples = same_frame(16'sh7FFF);
      s.gap = (i == 3) ? 2 : 0;
      pending_q.push_back(s);
    end
    for (int i = 0; i < WIN; i++) begin
      s.samples = same_frame(16'sh8000);
      s.gap = (i == 5) ? 1 : 0;
      pending_q.push_back(s);
    end
    s.gap = 0;
    s.samples = {16'sh5555, 16'sh0001, 16'shFFFF, 16'sh0000, 16'sh8000, 16'sh7FFF};
    pending_q.push_back(s);
    for (int i = 0; i < 6; i++) begin
      s.samples = (i % 2) ? same_frame(16'sh5555) : same_frame(16'shAAAA);
      if (i == 4) s.samples = same_frame(16'shFFFF);
      pending_q.push_back(s);
    end

    // Random: segments of fresh samples, constant runs and sign-saturated runs
    n = 0;
    while (n < RAND_ITEMS) begin
      mode    = $urandom_range(0, 9);
      run_len = $urandom_range(4, 20);
      quiet   = ($urandom_range(0, 5) == 0);
      for (int c = 0; c < NCHAN; c++) f[c] = draw_sample();
      for (int i = 0; i < run_len; i++) begin
        if (mode < 6) begin
          for (int c = 0; c < NCHAN; c++) s.samples[c] = draw_sample();
        end else if (mode < 8) begin
          s.samples = f;
        end else begin
          for (int c = 0; c < NCHAN; c++)
            s.samples[c] = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end
        s.gap = pick_gap(quiet);
        pending_q.push_back(s);
        n++;
      end
    end
    total_items = pending_q.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count != total_items) @(posedge clk);
    while (means_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
